>>> rtl/dsp_multiply_accumulate_unit_assert.svh
// Assertion macros shared by the multiply-accumulate unit modules.
// Depends on nothing; files that assert take it in by include.
`ifndef DSP_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH
`define DSP_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define DMAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dmac assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define DMAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dmac assertion failed");
`else
`define DMAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DMAC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/dmac_pkg.sv
// Types, codes and constants of the multiply-accumulate unit.
// Depends on nothing; every other module imports it.
package dmac_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int DATA_W      = 40;
	localparam int CFG_INDEX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNSIGNED_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_DOUBLING = 1'd1;

	// Action codes of an input item.
	localparam logic [2:0] ACT_MUL      = 3'd0;
	localparam logic [2:0] ACT_MADD     = 3'd1;
	localparam logic [2:0] ACT_MSUB     = 3'd2;
	localparam logic [2:0] ACT_ACC_ADD  = 3'd3;
	localparam logic [2:0] ACT_MOVE     = 3'd4;
	localparam logic [2:0] ACT_MOVE_CLR = 3'd5;

	// Product register operations carried out by the back part.
	localparam logic [1:0] PROD_KEEP = 2'd0;
	localparam logic [1:0] PROD_LOAD = 2'd1;
	localparam logic [1:0] PROD_ADD  = 2'd2;
	localparam logic [1:0] PROD_SUB  = 2'd3;

	// Accumulator operations carried out by the back part.
	localparam logic [1:0] ACC_KEEP     = 2'd0;
	localparam logic [1:0] ACC_ADD      = 2'd1;
	localparam logic [1:0] ACC_MOVE     = 2'd2;
	localparam logic [1:0] ACC_MOVE_CLR = 2'd3;

	// A move with the low part cleared keeps only the upper 24 bits.
	localparam logic [DATA_W-1:0] LOW_CLEAR_MASK = 40'hff_ffff_0000;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [15:0] operand_a;
		logic signed [15:0] operand_b;
		logic               part_select_form;
		logic               a_is_high;
		logic               b_is_high;
		logic               acc_select;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product_value;
		logic [DATA_W-1:0]        acc_value;
		logic                     acc_written;
	} result_t;

	typedef struct packed {
		logic unsigned_mode;
		logic skip_doubling;
	} cfg_t;

	// Classified item as it travels from the front part to the back part.
	typedef struct packed {
		logic [1:0]        prod_op;
		logic [1:0]        acc_op;
		logic              acc_sel;
		logic [DATA_W-1:0] product;
	} op_t;

endpackage

>>> rtl/dsp_multiply_accumulate_unit.sv
// Top level of the multiply-accumulate unit: configuration registers, front
// part, queue and back part. Depends on dmac_pkg, dmac_front, dmac_queue, dmac_back.
//
// Channel   Direction  Handshake             Payload
// item      in         item_valid/item_stall  dmac_pkg::item_t
// result    out        result_valid/stall     dmac_pkg::result_t
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item is accepted per cycle while item_stall is low; its result passes through
// the front stage register, a queue entry and the state update with the result
// register before it is valid and can be taken.
// The product register feedback add in the back part sets the one-cycle rate.
// Reset clears the product register, both accumulators and the configuration.
// A stalled result holds in its register while up to QDEPTH more beats wait in
// the queue and one more in the front stage; after that item_stall rises.
module dsp_multiply_accumulate_unit #(
	parameter int QDEPTH = dmac_pkg::QUEUE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  dmac_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output dmac_pkg::result_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dmac_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic                                 cfg_data
);
	import dmac_pkg::*;

	cfg_t cfg_q;
	logic f_valid;
	logic f_ready;
	op_t  f_op;
	logic b_valid;
	logic b_ready;
	op_t  b_op;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_UNSIGNED_MODE: cfg_q.unsigned_mode <= cfg_data;
				CFG_SKIP_DOUBLING: cfg_q.skip_doubling <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	dmac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.op_valid   (f_valid),
		.op_ready   (f_ready),
		.op         (f_op)
	);

	dmac_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_op)
	);

	dmac_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (b_valid),
		.op_ready     (b_ready),
		.op           (b_op),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> rtl/dmac_front.sv
// Front part: accepts input beats, classifies the action and forms the product.
// Depends on dmac_pkg.
module dmac_front (
	input  logic           clk,
	input  logic           arst_n,
	input  dmac_pkg::cfg_t cfg,
	input  logic           item_valid,
	output logic           item_stall,
	input  dmac_pkg::item_t item,
	output logic           op_valid,
	input  logic           op_ready,
	output dmac_pkg::op_t  op
);
	import dmac_pkg::*;

	logic               s1_valid_q;
	op_t                op_s1;
	op_t                op_d;
	logic               accept;
	logic               mixed;
	logic               ua;
	logic               ub;
	logic               signed_only;
	logic signed [16:0] a_ext;
	logic signed [16:0] b_ext;
	logic signed [33:0] prod;
	logic [DATA_W-1:0]  prod_ext;

	// The stage takes a new beat when empty or when its beat moves on.
	assign item_stall = s1_valid_q && !op_ready;
	assign accept     = item_valid && !item_stall;

	// Multiply-add and multiply-subtract always use signed operands.
	assign signed_only = (item.action == ACT_MADD) || (item.action == ACT_MSUB);

	// Decode the action into product and accumulator operations.
	always_comb begin
		op_d.prod_op = PROD_KEEP;
		op_d.acc_op  = ACC_KEEP;
		case (item.action)
			ACT_MUL: begin
				op_d.prod_op = PROD_LOAD;
			end
			ACT_MADD: begin
				op_d.prod_op = PROD_ADD;
			end
			ACT_MSUB: begin
				op_d.prod_op = PROD_SUB;
			end
			ACT_ACC_ADD: begin
				op_d.prod_op = PROD_LOAD;
				op_d.acc_op  = ACC_ADD;
			end
			ACT_MOVE: begin
				op_d.prod_op = PROD_LOAD;
				op_d.acc_op  = ACC_MOVE;
			end
			ACT_MOVE_CLR: begin
				op_d.prod_op = PROD_LOAD;
				op_d.acc_op  = ACC_MOVE_CLR;
			end
			default: begin
				op_d.prod_op = PROD_KEEP;
				op_d.acc_op  = ACC_KEEP;
			end
		endcase
		op_d.acc_sel = item.acc_select;
		op_d.product = prod_ext;
	end

	// Low-part operands become unsigned in unsigned mode for part-select forms.
	assign mixed = item.part_select_form && cfg.unsigned_mode && !signed_only;
	assign ua    = mixed && !item.a_is_high;
	assign ub    = mixed && !item.b_is_high;
	assign a_ext = {(ua ? 1'b0 : item.operand_a[15]), item.operand_a};
	assign b_ext = {(ub ? 1'b0 : item.operand_b[15]), item.operand_b};

	// A 17 by 17 signed multiply, sign extended and doubled unless told not to.
	always_comb begin
		prod     = a_ext * b_ext;
		prod_ext = {{(DATA_W - 34){prod[33]}}, prod};
		if (!cfg.skip_doubling) begin
			prod_ext = {prod_ext[DATA_W-2:0], 1'b0};
		end
	end

	// Stage register; the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (op_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_d;
		end
	end

	assign op_valid = s1_valid_q;
	assign op       = op_s1;

endmodule

>>> rtl/dmac_queue.sv
// Short queue of classified beats between the front and back parts.
// Depends on dmac_pkg and the assertion header.
`include "dsp_multiply_accumulate_unit_assert.svh"
module dmac_queue #(
	parameter int DEPTH = dmac_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  dmac_pkg::op_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output dmac_pkg::op_t pop_data
);
	import dmac_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = count_q < CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Storage is written at the tail; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Occupancy never passes the depth and follows pushes and pops.
	`DMAC_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`DMAC_ASSERT_NXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)
	`DMAC_ASSERT_NXT(a_count_same, clk, arst_n, push && pop, $stable(count_q))

endmodule

>>> rtl/dmac_back.sv
// Back part: holds the product register and accumulators, updates them and
// registers the result beat. Depends on dmac_pkg and the assertion header.
`include "dsp_multiply_accumulate_unit_assert.svh"
module dmac_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_ready,
	input  dmac_pkg::op_t    op,
	output logic             result_valid,
	input  logic             result_stall,
	output dmac_pkg::result_t result
);
	import dmac_pkg::*;

	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] acc_q [2];
	logic              res_valid_q;
	result_t           res_q;
	logic              pop;
	logic [DATA_W-1:0] prod_d;
	logic [DATA_W-1:0] acc_cur;
	logic [DATA_W-1:0] acc_d;
	logic              acc_wr;

	// A beat is taken when the result register is empty or being emptied.
	assign op_ready = !res_valid_q || !result_stall;
	assign pop      = op_valid && op_ready;

	// New product register value; sums wrap at 40 bits.
	always_comb begin
		case (op.prod_op)
			PROD_LOAD: prod_d = op.product;
			PROD_ADD:  prod_d = prod_q + op.product;
			PROD_SUB:  prod_d = prod_q - op.product;
			default:   prod_d = prod_q;
		endcase
	end

	// New accumulator value, taken from the old product register.
	always_comb begin
		acc_cur = acc_q[op.acc_sel];
		acc_wr  = op.acc_op != ACC_KEEP;
		case (op.acc_op)
			ACC_ADD:      acc_d = acc_cur + prod_q;
			ACC_MOVE:     acc_d = prod_q;
			ACC_MOVE_CLR: acc_d = prod_q & LOW_CLEAR_MASK;
			default:      acc_d = acc_cur;
		endcase
	end

	// Architectural state and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q      <= '0;
			acc_q[0]    <= '0;
			acc_q[1]    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				prod_q <= prod_d;
				if (acc_wr) begin
					acc_q[op.acc_sel] <= acc_d;
				end
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.product_value <= prod_d;
			res_q.acc_value     <= acc_d;
			res_q.acc_written   <= acc_wr;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// State only moves when a beat is carried out, and only as its operation says.
	`DMAC_ASSERT_NXT(a_prod_hold, clk, arst_n, !pop, $stable(prod_q))
	`DMAC_ASSERT_NXT(a_acc_hold, clk, arst_n, !pop || !acc_wr, $stable(acc_q[0]) && $stable(acc_q[1]))
	`DMAC_ASSERT_NXT(a_res_from_pop, clk, arst_n, !pop && !res_valid_q, !res_valid_q)

endmodule
